FILE: rtl/graph_bfs_dfs_traversal_assert.svh
// Assertion macros shared by the traversal RTL.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GBT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbt assertion failed");
// next-cycle implication
`define GBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbt assertion failed");
`else
`define GBT_ASSERT(lbl, ante, cons)
`define GBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/gbt_pkg.sv
package gbt_pkg;

  localparam int VW     = 6;   // vertex field width
  localparam int NW     = 7;   // num_vertices register width
  localparam int OPW    = 2;   // opcode width
  localparam int ROWW   = 64;  // widest adjacency row handled by the bit search
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [NW-1:0] NUM_VERTICES_RST = 7'd64;
  // register index is paddr[2]
  localparam logic REG_IDX_NUM_VERTICES = 1'b0;

  typedef enum logic [OPW-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BFS   = 2'd2,
    OP_DFS   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ASEL_A   = 2'd0,
    ASEL_B   = 2'd1,
    ASEL_CUR = 2'd2
  } adj_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     clr_rows;
    logic     adj_rd;
    adj_sel_t adj_sel;
    logic     adj_wr;
    logic     init;
    logic     qs_rd;
    logic     take_cur;
    logic     load_cand;
    logic     push;
    logic     pop;
    logic     emit_new;
    logic     emit_pick;
    logic     emit_err;
    logic     emit_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic start_bad;
    logic edge_ok;
    logic is_dfs;
    logic q_empty;
    logic depth_one;
    logic cand_any;
    logic out_free;
  } dp_stat_t;

  // index of the lowest set bit, searched as 8 groups of 8
  function automatic logic [5:0] lowest_set(input logic [ROWW-1:0] bits);
    logic [7:0] grp_any;
    logic [7:0] grp;
    logic [2:0] g;
    logic [2:0] k;
    for (int i = 0; i < 8; i++) grp_any[i] = |bits[8*i +: 8];
    g = '0;
    for (int i = 7; i >= 0; i--) if (grp_any[i]) g = 3'(i);
    grp = bits[{g, 3'b000} +: 8];
    k = '0;
    for (int i = 7; i >= 0; i--) if (grp[i]) k = 3'(i);
    return {g, k};
  endfunction

endpackage

FILE: rtl/gbt_ram.sv
module gbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/gbt_dp.sv
`include "graph_bfs_dfs_traversal_assert.svh"

module gbt_dp #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gbt_pkg::dp_cmd_t           cmd,
  output gbt_pkg::dp_stat_t          stat,
  input  logic [gbt_pkg::OPW-1:0]    in_op,
  input  logic [gbt_pkg::VW-1:0]     in_a,
  input  logic [gbt_pkg::VW-1:0]     in_b,
  input  logic [gbt_pkg::NW-1:0]     num_vertices,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [gbt_pkg::VW-1:0]     out_vertex,
  output logic                       out_last,
  output logic                       out_error
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int PW = AW + 1;
  localparam logic [gbt_pkg::NW-1:0] MAX_N = gbt_pkg::NW'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ONE_ROW = MAX_VERTICES'(1);

  logic [AW-1:0]           a_q;
  logic [AW-1:0]           b_q;
  logic                    dfs_q;
  logic [AW-1:0]           cur;
  logic [MAX_VERTICES-1:0] cand;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    rowv_q;
  logic [PW-1:0]           head;
  logic [PW-1:0]           ptr;
  logic [PW-1:0]           ptr_dec;
  logic [AW-1:0]           pend;
  logic                    pend_valid;
  logic [AW-1:0]           out_v;

  logic [gbt_pkg::NW-1:0]  n_eff;
  logic [MAX_VERTICES-1:0] nmask;

  logic [AW-1:0]           adj_raddr;
  logic [AW-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic [MAX_VERTICES-1:0] adj_row;

  logic                    qs_we;
  logic [AW-1:0]           qs_waddr;
  logic [AW-1:0]           qs_wdata;
  logic [AW-1:0]           qs_raddr;
  logic [AW-1:0]           qs_rdata;

  logic [gbt_pkg::ROWW-1:0] cand_wide;
  logic [5:0]               pick_full;
  logic [AW-1:0]            pick;
  logic [AW-1:0]            emit_v;
  logic                     out_load;

  assign n_eff = (num_vertices > MAX_N) ? MAX_N : num_vertices;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_nmask
    assign nmask[i] = gbt_pkg::NW'(i) < n_eff;
  end

  // adjacency rows; a row never written since the last clear reads as zero
  always_comb begin
    unique case (cmd.adj_sel)
      gbt_pkg::ASEL_A:   adj_raddr = a_q;
      gbt_pkg::ASEL_B:   adj_raddr = b_q;
      gbt_pkg::ASEL_CUR: adj_raddr = cur;
      default:           adj_raddr = a_q;
    endcase
  end

  assign adj_row   = rowv_q ? adj_rdata : '0;
  assign adj_waddr = (cmd.adj_sel == gbt_pkg::ASEL_B) ? b_q : a_q;
  assign adj_wdata = adj_row | (ONE_ROW << ((cmd.adj_sel == gbt_pkg::ASEL_B) ? a_q : b_q));

  gbt_ram #(
    .WIDTH(MAX_VERTICES),
    .DEPTH(MAX_VERTICES)
  ) u_adj (
    .clk   (clk),
    .we    (cmd.adj_wr),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (cmd.adj_rd),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // shared vertex store: FIFO for breadth-first, stack for depth-first
  assign ptr_dec  = ptr - PW'(1);
  assign qs_we    = cmd.init | cmd.push;
  assign qs_waddr = cmd.init ? '0 : ptr[AW-1:0];
  assign qs_wdata = cmd.init ? a_q : pick;
  assign qs_raddr = dfs_q ? ptr_dec[AW-1:0] : head[AW-1:0];

  gbt_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_VERTICES)
  ) u_qs (
    .clk   (clk),
    .we    (qs_we),
    .waddr (qs_waddr),
    .wdata (qs_wdata),
    .re    (cmd.qs_rd),
    .raddr (qs_raddr),
    .rdata (qs_rdata)
  );

  assign cand_wide = gbt_pkg::ROWW'(cand);
  assign pick_full = gbt_pkg::lowest_set(cand_wide);
  assign pick      = pick_full[AW-1:0];
  assign emit_v    = cmd.emit_pick ? pick : qs_rdata;
  // a new vertex pushes the held one out; the held one goes last at the end
  assign out_load  = cmd.emit_err | cmd.emit_fin | (cmd.emit_new & pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      dfs_q      <= 1'b0;
      row_valid  <= '0;
      rowv_q     <= 1'b0;
      visited    <= '0;
      head       <= '0;
      ptr        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.latch_in) begin
        dfs_q <= in_op == gbt_pkg::OP_DFS;
      end
      if (cmd.clr_rows) begin
        row_valid <= '0;
      end else if (cmd.adj_wr) begin
        row_valid[adj_waddr] <= 1'b1;
      end
      if (cmd.adj_rd) begin
        rowv_q <= row_valid[adj_raddr];
      end
      if (cmd.init) begin
        visited <= ONE_ROW << a_q;
        head    <= '0;
        ptr     <= PW'(1);
      end else if (cmd.push) begin
        visited <= visited | (ONE_ROW << pick);
        ptr     <= ptr + PW'(1);
      end else if (cmd.pop) begin
        ptr <= ptr_dec;
      end
      if (cmd.qs_rd && !dfs_q) begin
        head <= head + PW'(1);
      end
      if (cmd.init) begin
        pend_valid <= dfs_q;
      end else if (cmd.emit_new) begin
        pend_valid <= 1'b1;
      end else if (cmd.emit_fin) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_q <= in_a[AW-1:0];
      b_q <= in_b[AW-1:0];
    end
    if (cmd.init) begin
      cur <= a_q;
    end else if (cmd.take_cur) begin
      cur <= qs_rdata;
    end else if (cmd.push && dfs_q) begin
      cur <= pick;
    end
    if (cmd.load_cand) begin
      cand <= adj_row & ~visited & nmask;
    end else if (cmd.push) begin
      cand <= cand & (cand - ONE_ROW);
    end
    if (cmd.init || cmd.emit_new) begin
      pend <= cmd.init ? a_q : emit_v;
    end
    if (out_load) begin
      out_v     <= cmd.emit_err ? '0 : pend;
      out_last  <= cmd.emit_err | cmd.emit_fin;
      out_error <= cmd.emit_err;
    end
  end

  assign out_vertex = gbt_pkg::VW'(out_v);

  always_comb begin
    stat.start_bad = {1'b0, in_a} >= n_eff;
    stat.edge_ok   = ({1'b0, in_a} < MAX_N) && ({1'b0, in_b} < MAX_N);
    stat.is_dfs    = dfs_q;
    stat.q_empty   = head == ptr;
    stat.depth_one = ptr == PW'(1);
    stat.cand_any  = |cand;
    stat.out_free  = !out_valid || out_ready;
  end

  `GBT_ASSERT(a_ptr_bound, 1'b1, ptr <= PW'(MAX_VERTICES))
  `GBT_ASSERT(a_head_le_ptr, 1'b1, head <= ptr)
  `GBT_ASSERT(a_push_has_cand, cmd.push, cand != '0)
  `GBT_ASSERT(a_emit_when_free, cmd.emit_err || cmd.emit_fin || cmd.emit_new, stat.out_free)
  `GBT_ASSERT_NEXT(a_fin_drains, cmd.emit_fin && pend_valid, !pend_valid && out_valid && out_last)

endmodule

FILE: rtl/gbt_ctrl.sv
module gbt_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [gbt_pkg::OPW-1:0] in_op,
  output logic                    in_ready,
  input  gbt_pkg::dp_stat_t       stat,
  output gbt_pkg::dp_cmd_t        cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_ADD_RA = 13'b0000000000010,
    S_ADD_WA = 13'b0000000000100,
    S_ADD_RB = 13'b0000000001000,
    S_ADD_WB = 13'b0000000010000,
    S_ERR    = 13'b0000000100000,
    S_INIT   = 13'b0000001000000,
    S_POP    = 13'b0000010000000,
    S_TAKE   = 13'b0000100000000,
    S_RDA    = 13'b0001000000000,
    S_LOAD   = 13'b0010000000000,
    S_SCAN   = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (gbt_pkg::op_t'(in_op))
            gbt_pkg::OP_CLEAR: cmd.clr_rows = 1'b1;
            gbt_pkg::OP_ADD: begin
              if (stat.edge_ok) state_next = S_ADD_RA;
            end
            gbt_pkg::OP_BFS, gbt_pkg::OP_DFS: begin
              state_next = stat.start_bad ? S_ERR : S_INIT;
            end
          endcase
        end
      end
      S_ADD_RA: begin
        cmd.adj_rd  = 1'b1;
        cmd.adj_sel = gbt_pkg::ASEL_A;
        state_next  = S_ADD_WA;
      end
      S_ADD_WA: begin
        cmd.adj_wr  = 1'b1;
        cmd.adj_sel = gbt_pkg::ASEL_A;
        state_next  = S_ADD_RB;
      end
      S_ADD_RB: begin
        cmd.adj_rd  = 1'b1;
        cmd.adj_sel = gbt_pkg::ASEL_B;
        state_next  = S_ADD_WB;
      end
      S_ADD_WB: begin
        cmd.adj_wr  = 1'b1;
        cmd.adj_sel = gbt_pkg::ASEL_B;
        state_next  = S_IDLE;
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = stat.is_dfs ? S_RDA : S_POP;
      end
      S_POP: begin
        if (!stat.is_dfs && stat.q_empty) begin
          state_next = S_FIN;
        end else begin
          cmd.qs_rd  = 1'b1;
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        if (stat.is_dfs) begin
          cmd.take_cur = 1'b1;
          state_next   = S_RDA;
        end else if (stat.out_free) begin
          // breadth-first reports a vertex when it leaves the queue
          cmd.take_cur = 1'b1;
          cmd.emit_new = 1'b1;
          state_next   = S_RDA;
        end
      end
      S_RDA: begin
        cmd.adj_rd  = 1'b1;
        cmd.adj_sel = gbt_pkg::ASEL_CUR;
        state_next  = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_cand = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (stat.cand_any) begin
          if (!stat.is_dfs) begin
            cmd.push = 1'b1;
          end else if (stat.out_free) begin
            // descend into the lowest unvisited neighbor
            cmd.push      = 1'b1;
            cmd.emit_new  = 1'b1;
            cmd.emit_pick = 1'b1;
            state_next    = S_RDA;
          end
        end else if (stat.is_dfs) begin
          cmd.pop    = 1'b1;
          state_next = stat.depth_one ? S_FIN : S_POP;
        end else begin
          state_next = S_POP;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit_fin = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/graph_bfs_dfs_traversal.sv
// Graph traversal engine over an undirected adjacency bit matrix.
// Input stream (s_axis_*): tuser carries the opcode (clear edges, add edge,
// breadth-first, depth-first), tdata the two vertex fields. Output stream
// (m_axis_*): one transaction per visited vertex in visiting order, tlast on
// the final one, tuser set on the single result of an out-of-range start.
// APB register 0 holds num_vertices; write it only while the engine is idle.
// One item is in flight at a time; s_axis_tready is high only when idle.
// Add edge reads and rewrites the row of each end in turn. The pace of a
// traversal is set by the single read port of the adjacency row RAM, one row
// per step.
// Results leave through a one-deep output register; a stalled m_axis_tready
// holds the engine at its next emission without losing anything.
// Reset clears all edges at once through per-row valid bits, sets
// num_vertices to 64 and empties the output.
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // vertex_a[5:0], vertex_b[11:6]
  input  logic [gbt_pkg::OPW-1:0]    s_axis_tuser,  // opcode[1:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // vertex[5:0]
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser,  // error[0]
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbt_pkg::APB_AW-1:0] paddr,
  input  logic [gbt_pkg::APB_DW-1:0] pwdata,
  output logic [gbt_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  gbt_pkg::dp_cmd_t         cmd;
  gbt_pkg::dp_stat_t        stat;
  logic [gbt_pkg::NW-1:0]   num_vertices;
  logic [gbt_pkg::VW-1:0]   out_vertex;
  logic                     reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == gbt_pkg::REG_IDX_NUM_VERTICES;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= gbt_pkg::NUM_VERTICES_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      num_vertices <= pwdata[gbt_pkg::NW-1:0];
    end
  end

  assign prdata = reg_hit ? gbt_pkg::APB_DW'(num_vertices) : '0;

  gbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbt_dp #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (s_axis_tuser),
    .in_a         (s_axis_tdata[5:0]),
    .in_b         (s_axis_tdata[11:6]),
    .num_vertices (num_vertices),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_vertex   (out_vertex),
    .out_last     (m_axis_tlast),
    .out_error    (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, out_vertex};

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned QUIET_LIMIT   = 5000;  // cycles with no transaction on either side
  localparam int unsigned SETTLE_CYCLES = 20;    // long enough for an add edge to finish, margin on top
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic [gbt_pkg::APB_AW-1:0] NUM_VERTICES_ADDR = 3'd0;

  typedef struct packed {
    bit [5:0] vertex;
    bit       last;
    bit       err;
  } visit_t;

  // Tracks the graph and num_vertices, and expands each traversal into its visit order.
  class traversal_scoreboard;
    bit [63:0]   adj_rows [64];
    bit [6:0]    vertex_limit = gbt_pkg::NUM_VERTICES_RST;
    visit_t      pending_visits [$];
    int unsigned failures;

    function void note_input(gbt_pkg::op_t op, bit [5:0] a, bit [5:0] b);
      bit [63:0] seen;
      bit [5:0]  order [$];
      bit [5:0]  fifo [$];
      bit [5:0]  stack [$];
      bit [5:0]  cur;
      bit [6:0]  n;
      int        nxt;
      visit_t    item;
      n = (vertex_limit > 7'd64) ? 7'd64 : vertex_limit;
      case (op)
        gbt_pkg::OP_CLEAR: begin
          foreach (adj_rows[r]) adj_rows[r] = '0;
        end
        gbt_pkg::OP_ADD: begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
        end
        default: begin
          if (a >= n) begin
            item = '{vertex: 6'd0, last: 1'b1, err: 1'b1};
            pending_visits.push_back(item);
            return;
          end
          seen = '0;
          seen[a] = 1'b1;
          if (op == gbt_pkg::OP_BFS) begin
            fifo.push_back(a);
            while (fifo.size() != 0) begin
              cur = fifo.pop_front();
              order.push_back(cur);
              for (int i = 0; i < n; i++) begin
                if (adj_rows[cur][i] && !seen[i]) begin
                  seen[i] = 1'b1;
                  fifo.push_back(6'(i));
                end
              end
            end
          end else begin
            // explicit stack: descend to the lowest unvisited neighbor, else backtrack
            stack.push_back(a);
            order.push_back(a);
            while (stack.size() != 0) begin
              cur = stack[$];
              nxt = -1;
              for (int i = n - 1; i >= 0; i--) begin
                if (adj_rows[cur][i] && !seen[i]) nxt = i;
              end
              if (nxt >= 0) begin
                seen[nxt] = 1'b1;
                order.push_back(6'(nxt));
                stack.push_back(6'(nxt));
              end else begin
                void'(stack.pop_back());
              end
            end
          end
          foreach (order[k]) begin
            item = '{vertex: order[k], last: (k == order.size() - 1), err: 1'b0};
            pending_visits.push_back(item);
          end
        end
      endcase
    endfunction

    function void check_result(logic [5:0] vertex, logic last, logic err);
      visit_t want;
      if (pending_visits.size() == 0) begin
        failures++;
        $display("%0t: unexpected result: expected none, actual vertex %0d last %b error %b",
                 $time, vertex, last, err);
        return;
      end
      want = pending_visits.pop_front();
      if ({vertex, last, err} !== {want.vertex, want.last, want.err}) begin
        failures++;
        $display("%0t: mismatch: expected vertex %0d last %b error %b, ",
                 $time, want.vertex, want.last, want.err,
                 "actual vertex %0d last %b error %b", vertex, last, err);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata = '0;  // vertex_a[5:0], vertex_b[11:6]
  logic [gbt_pkg::OPW-1:0]      s_axis_tuser = '0;  // opcode[1:0]
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [7:0]                   m_axis_tdata;       // vertex[5:0]
  logic                         m_axis_tlast;
  logic                         m_axis_tuser;       // error[0]
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [gbt_pkg::APB_AW-1:0]   paddr = '0;
  logic [gbt_pkg::APB_DW-1:0]   pwdata = '0;
  logic [gbt_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  traversal_scoreboard sb = new;
  bit                  steady = 1'b0;    // no random idling on either side while set
  bit                  hold_req = 1'b0;
  int unsigned         quiet_cycles = 0;

  graph_bfs_dfs_traversal i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random backpressure, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[5:0], m_axis_tlast, m_axis_tuser);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the transaction is accepted
  task automatic send_item(input gbt_pkg::op_t op, input bit [5:0] a, input bit [5:0] b);
    if (!steady && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, b, a};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, a, b);
  endtask

  task automatic write_num_vertices(input bit [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_VERTICES_ADDR;
    pwdata  <= gbt_pkg::APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.vertex_limit = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random graphs: mostly edges among vertices in use, with traversals mixed in
  task automatic run_random_phase(input int unsigned count);
    int unsigned lim;
    int unsigned r;
    bit [5:0]    a;
    bit [5:0]    b;
    for (int unsigned k = 0; k < count; k++) begin
      lim = (sb.vertex_limit == 0) ? 1 : ((sb.vertex_limit > 64) ? 64 : sb.vertex_limit);
      r = $urandom_range(0, 99);
      a = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, lim - 1));
      b = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, lim - 1));
      if (r < 4)
        send_item(gbt_pkg::OP_CLEAR, a, b);
      else if (r < 62)
        send_item(gbt_pkg::OP_ADD, a, b);
      else if (r < 81)
        send_item(gbt_pkg::OP_BFS, a, b);
      else
        send_item(gbt_pkg::OP_DFS, a, b);
    end
  endtask

  initial begin
    bit [6:0]    nv_plan [7];
    int unsigned item_plan [7];

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty graph, then a small graph with a self loop and repeated edges
    send_item(gbt_pkg::OP_BFS, 6'd0, 6'd63);
    send_item(gbt_pkg::OP_DFS, 6'd63, 6'd0);
    send_item(gbt_pkg::OP_ADD, 6'd0, 6'd1);
    send_item(gbt_pkg::OP_ADD, 6'd1, 6'd2);
    send_item(gbt_pkg::OP_ADD, 6'd0, 6'd63);
    send_item(gbt_pkg::OP_ADD, 6'd63, 6'd62);
    send_item(gbt_pkg::OP_ADD, 6'd5, 6'd5);
    send_item(gbt_pkg::OP_ADD, 6'd2, 6'd0);
    send_item(gbt_pkg::OP_ADD, 6'd62, 6'd63);
    send_item(gbt_pkg::OP_BFS, 6'd0, 6'd42);
    send_item(gbt_pkg::OP_DFS, 6'd0, 6'd21);
    send_item(gbt_pkg::OP_BFS, 6'd5, 6'd0);
    send_item(gbt_pkg::OP_DFS, 6'd62, 6'd63);
    send_item(gbt_pkg::OP_CLEAR, 6'd63, 6'd63);
    send_item(gbt_pkg::OP_BFS, 6'd1, 6'd0);
    drain_results();

    // edges past num_vertices are stored but not followed
    write_num_vertices(7'd40);
    send_item(gbt_pkg::OP_BFS, 6'd45, 6'd0);
    send_item(gbt_pkg::OP_ADD, 6'd0, 6'd39);
    send_item(gbt_pkg::OP_ADD, 6'd39, 6'd50);
    send_item(gbt_pkg::OP_BFS, 6'd0, 6'd0);
    send_item(gbt_pkg::OP_DFS, 6'd39, 6'd0);
    send_item(gbt_pkg::OP_DFS, 6'd40, 6'd0);
    drain_results();

    write_num_vertices(7'd0);
    send_item(gbt_pkg::OP_BFS, 6'd0, 6'd0);
    send_item(gbt_pkg::OP_DFS, 6'd0, 6'd0);
    drain_results();

    // above the maximum saturates
    write_num_vertices(7'd127);
    send_item(gbt_pkg::OP_ADD, 6'd63, 6'd0);
    send_item(gbt_pkg::OP_BFS, 6'd63, 6'd0);
    send_item(gbt_pkg::OP_DFS, 6'd50, 6'd0);
    drain_results();

    write_num_vertices(7'd1);
    send_item(gbt_pkg::OP_BFS, 6'd0, 6'd0);
    send_item(gbt_pkg::OP_DFS, 6'd1, 6'd0);
    drain_results();

    // path through all 64 vertices: longest traversals, with a long output hold-off
    write_num_vertices(7'd64);
    steady = 1'b1;
    send_item(gbt_pkg::OP_CLEAR, 6'd0, 6'd0);
    for (int v = 0; v < 63; v++) begin
      if (v % 2 == 0)
        send_item(gbt_pkg::OP_ADD, 6'(v), 6'(v + 1));
      else
        send_item(gbt_pkg::OP_ADD, 6'(v + 1), 6'(v));
    end
    hold_req = 1'b1;
    send_item(gbt_pkg::OP_DFS, 6'd0, 6'd0);
    send_item(gbt_pkg::OP_BFS, 6'd31, 6'd0);
    send_item(gbt_pkg::OP_DFS, 6'd63, 6'd0);
    send_item(gbt_pkg::OP_BFS, 6'd0, 6'd0);
    drain_results();

    nv_plan   = '{7'd16, 7'd127, 7'd0, 7'd1, 7'($urandom_range(2, 63)),
                  7'($urandom_range(65, 126)), 7'd64};
    item_plan = '{80, 70, 25, 25, 80, 60, 80};
    foreach (nv_plan[p]) begin
      write_num_vertices(nv_plan[p]);
      send_item(gbt_pkg::OP_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      run_random_phase(item_plan[p]);
      steady = 1'b0;
      drain_results();
    end

    if (sb.failures == 0 && sb.pending_visits.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
